// ===== rtl/hms_pkg.sv =====
// Package: shared codes, field widths and item types for the up/down timer.
`timescale 1ns / 1ps

package hms_pkg;

    // Port field widths (fixed by the channel definition).
    localparam int FRAC_W   = 16;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOURS_W  = 10;
    localparam int FUNC_W   = 2;
    localparam int MASK_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_LOAD = 2'd1,
        FUNC_RUN  = 2'd2
    } func_t;

    // Load mask bit positions.
    localparam int MASK_FRAC  = 0;
    localparam int MASK_SEC   = 1;
    localparam int MASK_MIN   = 2;
    localparam int MASK_HOURS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_UP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_CONTROL = 2'd1;

    // Time-field limits.
    localparam logic [SEC_W-1:0] SEC_LAST = 6'd59;
    localparam logic [MIN_W-1:0] MIN_LAST = 6'd59;

    typedef struct packed {
        logic count_up;
        logic use_control;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAC_W-1:0]  delta_frac;
        logic               hold_l;
        logic               trig_down;
        logic               hold_right;
        logic               trig_left;
        logic [FRAC_W-1:0]  load_frac;
        logic [SEC_W-1:0]   load_sec;
        logic [MIN_W-1:0]   load_min;
        logic [HOURS_W-1:0] load_hours;
        logic [MASK_W-1:0]  load_mask;
        logic               run_value;
    } item_t;

endpackage

// ===== rtl/hms_if.sv =====
// Interfaces: command, result and configuration channels of the timer.
`timescale 1ns / 1ps

interface hms_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [hms_pkg::FUNC_W-1:0]  func;
    logic [hms_pkg::FRAC_W-1:0]  delta_frac;
    logic                        hold_l;
    logic                        trig_down;
    logic                        hold_right;
    logic                        trig_left;
    logic [hms_pkg::FRAC_W-1:0]  load_frac;
    logic [hms_pkg::SEC_W-1:0]   load_sec;
    logic [hms_pkg::MIN_W-1:0]   load_min;
    logic [hms_pkg::HOURS_W-1:0] load_hours;
    logic [hms_pkg::MASK_W-1:0]  load_mask;
    logic                        run_value;

    modport source (
        output valid, func, delta_frac, hold_l, trig_down, hold_right, trig_left,
               load_frac, load_sec, load_min, load_hours, load_mask, run_value,
        input  ready
    );
    modport sink (
        input  valid, func, delta_frac, hold_l, trig_down, hold_right, trig_left,
               load_frac, load_sec, load_min, load_hours, load_mask, run_value,
        output ready
    );
endinterface

interface hms_res_if;
    logic                        valid;
    logic                        ready;
    logic [hms_pkg::FRAC_W-1:0]  frac_now;
    logic [hms_pkg::SEC_W-1:0]   sec_now;
    logic [hms_pkg::MIN_W-1:0]   min_now;
    logic [hms_pkg::HOURS_W-1:0] hours_now;
    logic                        running;

    modport source (
        output valid, frac_now, sec_now, min_now, hours_now, running,
        input  ready
    );
    modport sink (
        input  valid, frac_now, sec_now, min_now, hours_now, running,
        output ready
    );
endinterface

interface hms_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hms_pkg::CFG_IDX_W-1:0]  index;
    logic [hms_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/hms_step.sv =====
// Next-state logic: controls, tick carry, loads and run flag for one item.
`timescale 1ns / 1ps

module hms_step #(
    parameter int FRAC_BITS = 16,
    parameter int HOUR_BITS = 10
) (
    input  hms_pkg::cfg_t                cfg,
    input  hms_pkg::item_t               item,
    input  logic [FRAC_BITS-1:0]         cur_frac,
    input  logic [hms_pkg::SEC_W-1:0]    cur_sec,
    input  logic [hms_pkg::MIN_W-1:0]    cur_min,
    input  logic [HOUR_BITS-1:0]         cur_hours,
    input  logic                         cur_run,
    output logic [FRAC_BITS-1:0]         nxt_frac,
    output logic [hms_pkg::SEC_W-1:0]    nxt_sec,
    output logic [hms_pkg::MIN_W-1:0]    nxt_min,
    output logic [HOUR_BITS-1:0]         nxt_hours,
    output logic                         nxt_run
);

    typedef struct packed {
        logic [hms_pkg::SEC_W-1:0] sec;
        logic [hms_pkg::MIN_W-1:0] min;
        logic [HOUR_BITS-1:0]      hours;
    } hms_t;

    // Step up one second; hold at the top of the hours range.
    function automatic hms_t step_up(input hms_t t);
        hms_t r;
        r = t;
        if (t.sec < hms_pkg::SEC_LAST) begin
            r.sec = t.sec + 1'b1;
        end else if (t.min < hms_pkg::MIN_LAST) begin
            r.sec = '0;
            r.min = t.min + 1'b1;
        end else if (t.hours != '1) begin
            r.sec   = '0;
            r.min   = '0;
            r.hours = t.hours + 1'b1;
        end
        return r;
    endfunction

    // Step down one second; leave an all-zero time alone.
    function automatic hms_t step_down(input hms_t t);
        hms_t r;
        r = t;
        if (t.sec != '0) begin
            r.sec = t.sec - 1'b1;
        end else if (t.min != '0) begin
            r.sec = hms_pkg::SEC_LAST;
            r.min = t.min - 1'b1;
        end else if (t.hours != '0) begin
            r.sec   = hms_pkg::SEC_LAST;
            r.min   = hms_pkg::MIN_LAST;
            r.hours = t.hours - 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        hms_t               t;
        logic [FRAC_BITS-1:0] f;
        logic               r;
        logic [FRAC_BITS:0] sum;

        t   = '{sec: cur_sec, min: cur_min, hours: cur_hours};
        f   = cur_frac;
        r   = cur_run;
        sum = '0;

        case (item.func)
            hms_pkg::FUNC_TICK:
            begin
                if (cfg.use_control) begin
                    if (item.hold_l) begin
                        if (item.trig_down) begin
                            f = '0;
                            t = '0;
                        end
                    end else begin
                        if (item.hold_right) begin
                            f = '0;
                            t = step_up(t);
                        end
                        if (item.trig_left) begin
                            f = '0;
                            if (t.min != '0) begin
                                t = step_down(t);
                            end
                        end
                    end
                end
                if (r) begin
                    sum = {1'b0, f} + {1'b0, FRAC_BITS'(item.delta_frac)};
                    f   = sum[FRAC_BITS-1:0];
                    if (sum[FRAC_BITS]) begin
                        if (cfg.count_up) begin
                            t = step_up(t);
                        end else if (t == '0) begin
                            // countdown expired: stop at zero
                            f = '0;
                            r = 1'b0;
                        end else begin
                            t = step_down(t);
                        end
                    end
                end
            end
            hms_pkg::FUNC_LOAD:
            begin
                if (item.load_mask[hms_pkg::MASK_FRAC])  f = FRAC_BITS'(item.load_frac);
                if (item.load_mask[hms_pkg::MASK_SEC])   t.sec = item.load_sec;
                if (item.load_mask[hms_pkg::MASK_MIN])   t.min = item.load_min;
                if (item.load_mask[hms_pkg::MASK_HOURS]) t.hours = HOUR_BITS'(item.load_hours);
            end
            hms_pkg::FUNC_RUN:
            begin
                r = item.run_value;
            end
            default:
            begin
            end
        endcase

        nxt_frac  = f;
        nxt_sec   = t.sec;
        nxt_min   = t.min;
        nxt_hours = t.hours;
        nxt_run   = r;
    end

endmodule

// ===== rtl/hms_up_down_timer.sv =====
// Top level: hours/minutes/seconds up/down timer with command register.
`timescale 1ns / 1ps

// Channel | Role | Moves
// --------+------+---------------------------------------------------------
// cmd     | sink | one item: tick, load under mask, or set running flag
// res     | src  | one item per command: time and running flag after it
// cfg     | sink | register write: index 0 count_up, index 1 use_control
//
// A command item passes a command register, then next-state logic that writes
// the time registers, which also serve as the result register. Throughput is
// one item per cycle unless the result side stalls; each result is valid the
// cycle after its item advances. The command register accepts a new item
// while a result waits, so a stalled result side fills at most one extra item
// before cmd.ready drops. Reset (rst_n low, asynchronous) clears the time,
// stops the timer, sets count_up and clears use_control. cfg is always ready.

module hms_up_down_timer #(
    parameter int FRAC_BITS = 16,
    parameter int HOUR_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    hms_cmd_if.sink           cmd,
    hms_res_if.source         res,
    hms_cfg_if.sink           cfg
);

    // Configuration registers.
    logic count_up_reg;
    logic use_control_reg;
    hms_pkg::cfg_t cfg_bits;

    // Command register.
    logic           pipe_valid_reg;
    logic           pipe_valid_next;
    hms_pkg::item_t item_reg;

    // Time state, doubling as the result register.
    logic                      res_valid_reg;
    logic                      res_valid_next;
    logic [FRAC_BITS-1:0]      frac_reg;
    logic [FRAC_BITS-1:0]      frac_next;
    logic [hms_pkg::SEC_W-1:0] sec_reg;
    logic [hms_pkg::SEC_W-1:0] sec_next;
    logic [hms_pkg::MIN_W-1:0] min_reg;
    logic [hms_pkg::MIN_W-1:0] min_next;
    logic [HOUR_BITS-1:0]      hours_reg;
    logic [HOUR_BITS-1:0]      hours_next;
    logic                      run_reg;
    logic                      run_next;

    logic cmd_take;
    logic advance;

    // The source must issue configuration writes only while idle (not enforced here); take them at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_up_reg    <= 1'b1;
            use_control_reg <= 1'b0;
        end else if (cfg.valid) begin
            case (cfg.index)
                hms_pkg::CFG_COUNT_UP:    count_up_reg    <= cfg.data[0];
                hms_pkg::CFG_USE_CONTROL: use_control_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_bits = '{count_up: count_up_reg, use_control: use_control_reg};

    // Advance the held item into the time registers once the result slot
    // is empty or its item is being taken this cycle.
    assign advance   = pipe_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !pipe_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        pipe_valid_next = pipe_valid_reg;
        if (cmd_take) begin
            pipe_valid_next = 1'b1;
        end else if (advance) begin
            pipe_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = 1'b1;
        end else if (res.ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pipe_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            pipe_valid_reg <= pipe_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Capture the command payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd_take) begin
            item_reg <= '{
                func:       cmd.func,
                delta_frac: cmd.delta_frac,
                hold_l:     cmd.hold_l,
                trig_down:  cmd.trig_down,
                hold_right: cmd.hold_right,
                trig_left:  cmd.trig_left,
                load_frac:  cmd.load_frac,
                load_sec:   cmd.load_sec,
                load_min:   cmd.load_min,
                load_hours: cmd.load_hours,
                load_mask:  cmd.load_mask,
                run_value:  cmd.run_value
            };
        end
    end

    hms_step #(
        .FRAC_BITS (FRAC_BITS),
        .HOUR_BITS (HOUR_BITS)
    ) u_step (
        .cfg       (cfg_bits),
        .item      (item_reg),
        .cur_frac  (frac_reg),
        .cur_sec   (sec_reg),
        .cur_min   (min_reg),
        .cur_hours (hours_reg),
        .cur_run   (run_reg),
        .nxt_frac  (frac_next),
        .nxt_sec   (sec_next),
        .nxt_min   (min_next),
        .nxt_hours (hours_next),
        .nxt_run   (run_next)
    );

    // Time is architectural state, so it resets to zero and stopped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frac_reg  <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hours_reg <= '0;
            run_reg   <= 1'b0;
        end else if (advance) begin
            frac_reg  <= frac_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hours_reg <= hours_next;
            run_reg   <= run_next;
        end
    end

    // Drive the result from the time registers, fitted to the port widths.
    assign res.valid     = res_valid_reg;
    assign res.frac_now  = hms_pkg::FRAC_W'(frac_reg);
    assign res.sec_now   = sec_reg;
    assign res.min_now   = min_reg;
    assign res.hours_now = hms_pkg::HOURS_W'(hours_reg);
    assign res.running   = run_reg;

`ifndef SYNTH
    // Command side only stalls when both stages are full and output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (pipe_valid_reg && res_valid_reg && !res.ready))
        else $error("cmd.ready low without a full stalled pipeline");

    // Every advance produces a pending result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced item did not reach the result register");

    // A held item that does not advance stays held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_valid_reg && !advance) |=> pipe_valid_reg)
        else $error("held command item lost");

    // Time state changes only when an item advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({frac_reg, sec_reg, min_reg, hours_reg, run_reg}))
        else $error("time state changed without an item");
`endif

endmodule
